@@ sv/utf8v_pkg.sv @@
// Shared types and byte-class constants for the UTF-8 stream validator.
`default_nettype none

package utf8v_pkg;

   typedef struct packed {
      logic [1:0] bytes_pending;
      logic       after_ed_lead;
      logic       error_seen;
   } utf8v_state_type;

   localparam logic [7:0] ASCII_MAX      = 8'h7F;
   localparam logic [7:0] LEAD2_MASK     = 8'hE0;
   localparam logic [7:0] LEAD2_CODE     = 8'hC0;
   localparam logic [7:0] LEAD3_MASK     = 8'hF0;
   localparam logic [7:0] LEAD3_CODE     = 8'hE0;
   localparam logic [7:0] LEAD4_MASK     = 8'hF8;
   localparam logic [7:0] LEAD4_CODE     = 8'hF0;
   localparam logic [7:0] CONT_MASK      = 8'hC0;
   localparam logic [7:0] CONT_CODE      = 8'h80;
   localparam logic [7:0] SURR_LEAD      = 8'hED;
   localparam logic [7:0] SURR_BITS      = 8'hA0;

   localparam logic [1:0] PEND_NONE      = 2'd0;
   localparam logic [1:0] PEND_TWO_BYTE  = 2'd1;
   localparam logic [1:0] PEND_THREE_BYTE = 2'd2;
   localparam logic [1:0] PEND_FOUR_BYTE = 2'd3;

   localparam utf8v_state_type STATE_CLEAR = '{
      bytes_pending: PEND_NONE,
      after_ed_lead: 1'b0,
      error_seen:    1'b0
   };

endpackage

`default_nettype wire

@@ sv/utf8_stream_validator_top.sv @@
// UTF-8 stream validator: one byte per item, verdict on the last byte.
//
// Takes one byte of a string per item and gives a single string_valid verdict
// on the item flagged last_byte; other items give no result. Throughput is one
// byte per clock while input is not stalled: the next-state decode is a few gates
// between the state registers, and the verdict sits in an output register so
// that input keeps flowing in any cycle where a held verdict is taken. A verdict
// appears in the cycle after its last byte is accepted. Input stalls only
// while a verdict is held and rsp_ready is low. Overlong forms and leads
// 0xF5-0xF7 are accepted; lead 0xED followed by a byte with bits 0xA0 set is rejected.
`default_nettype none

module utf8_stream_validator_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_string_valid
);
   import utf8v_pkg::*;

   utf8v_state_type state_ff, state_in;
   utf8v_state_type state_next;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_string_valid_ff, rsp_string_valid_in;
   logic            req_accept;

   utf8v_step u_step (
      .state_cur  (state_ff),
      .data_byte  (req_data_byte),
      .state_next (state_next)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      state_in            = state_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_string_valid_in = rsp_string_valid_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            state_in            = STATE_CLEAR;
            rsp_valid_in        = 1'b1;
            rsp_string_valid_in = !state_next.error_seen &&
                                  (state_next.bytes_pending == PEND_NONE);
         end else begin
            state_in = state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_string_valid_ff <= rsp_string_valid_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_string_valid = rsp_string_valid_ff;

   a_ed_needs_three_byte: assert property (@(posedge clock) disable iff (reset)
      state_ff.after_ed_lead |-> (state_ff.bytes_pending == PEND_THREE_BYTE))
      else $error("surrogate flag set outside a three-byte sequence");

   a_error_clears_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff.error_seen |-> (state_ff.bytes_pending == PEND_NONE && !state_ff.after_ed_lead))
      else $error("pending count kept after an error");

   a_last_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=> rsp_valid_ff)
      else $error("last byte accepted without a verdict");

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_last_byte) |=> (state_ff == STATE_CLEAR))
      else $error("state not cleared after the last byte");

endmodule

`default_nettype wire

@@ sv/utf8v_step.sv @@
// Next-state decode for one byte of the UTF-8 stream validator.
`default_nettype none

module utf8v_step (
   input  wire utf8v_pkg::utf8v_state_type state_cur,
   input  wire logic [7:0]                 data_byte,
   output utf8v_pkg::utf8v_state_type      state_next
);
   import utf8v_pkg::*;

   logic surrogate;
   logic not_cont;

   assign surrogate = state_cur.after_ed_lead && ((data_byte & SURR_BITS) == SURR_BITS);
   assign not_cont  = (data_byte & CONT_MASK) != CONT_CODE;

   always_comb begin
      state_next = STATE_CLEAR;
      if (state_cur.error_seen) begin
         // sticky: drop bytes until the last one
         state_next.error_seen = 1'b1;
      end else if (state_cur.bytes_pending != PEND_NONE) begin
         if (surrogate || not_cont) begin
            state_next.error_seen = 1'b1;
         end else begin
            state_next.bytes_pending = state_cur.bytes_pending - 2'd1;
         end
      end else if (data_byte <= ASCII_MAX) begin
         state_next.bytes_pending = PEND_NONE;
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
         state_next.bytes_pending = PEND_TWO_BYTE;
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
         state_next.bytes_pending = PEND_THREE_BYTE;
         state_next.after_ed_lead = (data_byte == SURR_LEAD);
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
         state_next.bytes_pending = PEND_FOUR_BYTE;
      end else begin
         state_next.error_seen = 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ dv/utf8_verdict_checker.sv @@
// Checker for the UTF-8 stream validator: predicts string verdicts and compares them.
`timescale 1ns / 1ps

module utf8_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_string_valid,
   output int         fail_count,
   output int         verdicts_owed,
   output int         verdicts_seen,
   output int         valid_seen
);
   import utf8v_pkg::*;

   utf8v_state_type scan;
   logic            pending_verdicts[$];

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("mismatch at %0d ns: %s", $time, what);
   endtask

   // Advance the scan state by one byte of the string.
   function automatic utf8v_state_type next_scan(input utf8v_state_type s,
                                                 input logic [7:0] b);
      utf8v_state_type n;
      n = s;
      n.after_ed_lead = 1'b0;
      if (s.error_seen) begin
         n.bytes_pending = PEND_NONE;
      end else if (s.bytes_pending != PEND_NONE) begin
         if ((s.after_ed_lead && (b & SURR_BITS) == SURR_BITS) ||
             (b & CONT_MASK) != CONT_CODE) begin
            n.error_seen    = 1'b1;
            n.bytes_pending = PEND_NONE;
         end else begin
            n.bytes_pending = s.bytes_pending - 2'd1;
         end
      end else if (b <= ASCII_MAX) begin
         n.bytes_pending = PEND_NONE;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         n.bytes_pending = PEND_TWO_BYTE;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         n.bytes_pending = PEND_THREE_BYTE;
         n.after_ed_lead = (b == SURR_LEAD);
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         n.bytes_pending = PEND_FOUR_BYTE;
      end else begin
         n.error_seen    = 1'b1;
         n.bytes_pending = PEND_NONE;
      end
      return n;
   endfunction

   always @(posedge clock) begin
      logic want;
      if (reset) begin
         scan = STATE_CLEAR;
         pending_verdicts.delete();
         verdicts_owed = 0;
      end else begin
         // Compare first: a verdict never leaves in the cycle its last byte enters.
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("verdict %0b with none expected",
                                         rsp_string_valid));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_string_valid !== want)
                  report_mismatch($sformatf("string_valid %b, expected %b",
                                            rsp_string_valid, want));
               verdicts_seen++;
               if (want) valid_seen++;
            end
         end
         if (req_valid && req_ready) begin
            scan = next_scan(scan, req_data_byte);
            if (req_last_byte) begin
               want = !scan.error_seen && scan.bytes_pending == PEND_NONE;
               pending_verdicts = {pending_verdicts, want};
               scan = STATE_CLEAR;
            end
         end
         verdicts_owed = pending_verdicts.size();
      end
   end

endmodule

@@ dv/testbench.sv @@
// Top of the UTF-8 stream validator testbench: clock, reset, byte strings and verdict.
`timescale 1ns / 1ps

module testbench;
   import utf8v_pkg::*;

   localparam int BYTE_TARGET = 1050;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_string_valid;

   int fails;
   int owed;
   int verdicts;
   int valid_verdicts;

   int send_idle_pct;
   int recv_idle_pct;
   bit want_hold;
   bit hold_done;
   int bytes_sent;
   int strings_sent;
   int quiet_cycles;

   logic [7:0] text[$];

   utf8_stream_validator_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_string_valid (rsp_string_valid)
   );

   utf8_verdict_checker verdict_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_string_valid (rsp_string_valid),
      .fail_count       (fails),
      .verdicts_owed    (owed),
      .verdicts_seen    (verdicts),
      .valid_seen       (valid_verdicts)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus one long hold-off when asked.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (want_hold && hold_left == 0) begin
            want_hold = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("no handshake for %0d cycles", quiet_cycles);
         $display("testbench: errors");
         $finish;
      end
   end

   // Offer every byte of text, the final one flagged last; return at the accepting edge.
   task automatic send_text();
      int  i;
      bit  rdy;
      for (i = 0; i < text.size(); i++) begin
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= text[i];
         req_last_byte <= (i == text.size() - 1);
         // ready only moves at the rising edge, so the falling edge shows its value at the next one
         do begin
            @(negedge clock);
            rdy = req_ready;
            @(posedge clock);
         end while (!rdy);
         bytes_sent++;
      end
      strings_sent++;
   endtask

   // Mostly well-formed strings with random content; some noise, some broken.
   task automatic build_random_text();
      int         chars;
      int         conts;
      int         roll;
      logic [7:0] lead;
      text.delete();
      if ($urandom_range(0, 99) < 12) begin
         repeat ($urandom_range(1, 6)) text = {text, 8'($urandom_range(0, 255))};
      end else begin
         chars = $urandom_range(1, 5);
         repeat (chars) begin
            case ($urandom_range(0, 3))
               0: begin
                  lead  = {1'b0, 7'($urandom_range(0, 127))};
                  conts = 0;
               end
               1: begin
                  lead  = {3'b110, 5'($urandom_range(0, 31))};
                  conts = 1;
               end
               2: begin
                  lead  = ($urandom_range(0, 3) == 0) ? SURR_LEAD
                                                      : {4'b1110, 4'($urandom_range(0, 15))};
                  conts = 2;
               end
               default: begin
                  lead  = {5'b11110, 3'($urandom_range(0, 7))};
                  conts = 3;
               end
            endcase
            text = {text, lead};
            repeat (conts) text = {text, {2'b10, 6'($urandom_range(0, 63))}};
         end
         roll = $urandom_range(0, 99);
         if (roll < 12)
            text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
         else if (roll < 20 && text.size() > 1)
            void'(text.pop_back());
      end
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= 8'h00;
      req_last_byte <= 1'b0;
      send_idle_pct = 18;
      recv_idle_pct = 80;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single bytes: ASCII extremes and bad leads
      text = '{8'h00};                      send_text();
      text = '{8'h7F};                      send_text();
      text = '{8'h80};                      send_text();
      text = '{8'hFF};                      send_text();
      // two, three and four byte characters
      text = '{8'hC2, 8'hA9};               send_text();
      text = '{8'hE2, 8'h82, 8'hAC};        send_text();
      text = '{8'hF0, 8'h9F, 8'h98, 8'h80}; send_text();
      // surrogate rejected, just below it accepted
      text = '{8'hED, 8'hA0, 8'h80};        send_text();
      text = '{8'hED, 8'h9F, 8'hBF};        send_text();
      // bad continuation, then bytes consumed until the end
      text = '{8'hC2, 8'h41, 8'h42};        send_text();
      // sequence cut short by the last byte
      text = '{8'hE2, 8'h82};               send_text();
      // overlong form passes
      text = '{8'hC0, 8'h80};               send_text();

      while (bytes_sent < BYTE_TARGET) begin
         if (bytes_sent >= 2 * BYTE_TARGET / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            if (!hold_done) begin
               // starve the output so the verdict register fills and input stalls
               want_hold = 1'b1;
               hold_done = 1'b1;
            end
         end else if (bytes_sent >= BYTE_TARGET / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 18;
         end
         build_random_text();
         send_text();
      end
      req_valid <= 1'b0;

      // let the checker take in the final item before draining
      @(posedge clock);
      while (owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d bytes in %0d strings under three stall mixes and a long output hold",
               bytes_sent, strings_sent);
      $display("checked %0d verdicts, %0d of them valid", verdicts, valid_verdicts);
      if (fails == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
